[src/bpq_pkg.sv]
// shared types and constants for the brightest pixel in quadrant block
// no dependencies
`timescale 1ns / 1ps

package bpq_pkg;

    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_REGION = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic [CHAN_W-1:0] GRAY_LEVEL = 8'd40;
    localparam logic [CHAN_W:0]   SAT_OFFSET = 9'd10;

    typedef struct packed {
        logic [1:0]         region;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_cfg;

    // one classified pixel, as queued between front and back
    typedef struct packed {
        logic              qual;
        logic              last;
        logic              has_image;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] diff;
    } t_item;

endpackage

[src/bpq_front.sv]
// front end: window test and max/min classification of each pixel
// depends on bpq_pkg
`timescale 1ns / 1ps

module bpq_front #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                          i_valid,
    input  logic [bpq_pkg::COORD_W-1:0]   i_col,
    input  logic [bpq_pkg::COORD_W-1:0]   i_row,
    input  logic [bpq_pkg::CHAN_W-1:0]    i_red,
    input  logic [bpq_pkg::CHAN_W-1:0]    i_green,
    input  logic [bpq_pkg::CHAN_W-1:0]    i_blue,
    input  logic                          i_last_pixel,
    input  bpq_pkg::t_cfg                 i_cfg,
    input  logic                          i_full,
    output logic                          o_stall,
    output logic                          o_push,
    output bpq_pkg::t_item                o_item
);

    localparam int CW      = bpq_pkg::COORD_W;
    localparam int FULL_LIM = (1 << CW) - 1;
    localparam int SIDE_LIM = (MAX_SIDE - 1 > FULL_LIM) ? FULL_LIM : MAX_SIDE - 1;
    localparam logic [CW-1:0] C_LIM = CW'(SIDE_LIM);

    logic [CW-1:0] w, h, half, ox, oy, dc, dr;
    logic          has_image, col_ok, row_ok;
    logic [bpq_pkg::CHAN_W-1:0] mx, mn;

    always_comb begin
        w = (i_cfg.width  > C_LIM) ? C_LIM : i_cfg.width;
        h = (i_cfg.height > C_LIM) ? C_LIM : i_cfg.height;
        has_image = (w != '0) && (h != '0);
        half = ((w < h) ? w : h) >> 1;
        ox = i_cfg.region[0] ? half : '0;
        oy = i_cfg.region[1] ? half : '0;
        dc = i_col - ox;
        dr = i_row - oy;
        col_ok = (i_col >= ox) && (dc < half) && !dc[0];
        row_ok = (i_row >= oy) && (dr < half) && !dr[0];

        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue  > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue  < mn) mn = i_blue;
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.qual      = has_image && col_ok && row_ok;
        o_item.last      = i_last_pixel;
        o_item.has_image = has_image;
        o_item.red       = i_red;
        o_item.green     = i_green;
        o_item.blue      = i_blue;
        o_item.mx        = mx;
        o_item.diff      = mx - mn;
    end

endmodule

[src/bpq_queue.sv]
// two-entry queue of classified pixels between front and back
// depends on bpq_pkg
`timescale 1ns / 1ps

module bpq_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bpq_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_avail,
    input  logic           i_pop,
    output bpq_pkg::t_item o_item
);

    bpq_pkg::t_item r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

endmodule

[src/bpq_back.sv]
// back end: saturation divider, best-pixel compare and result register
// depends on bpq_pkg
`timescale 1ns / 1ps

module bpq_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_avail,
    input  bpq_pkg::t_item             i_item,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bpq_pkg::CHAN_W-1:0] o_out_red,
    output logic [bpq_pkg::CHAN_W-1:0] o_out_green,
    output logic [bpq_pkg::CHAN_W-1:0] o_out_blue
);

    localparam int C = bpq_pkg::CHAN_W;
    localparam int RW = 2 * C + 1;    // dividend width: 510*255 + 255 fits

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DIV  = 1'b1;

    logic r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [RW-1:0] r_rem, n_rem, r_den, n_den;
    logic [C-1:0] r_q, n_q;
    bpq_pkg::t_item r_cur, n_cur;

    logic [C-1:0] r_hr, n_hr, r_hg, n_hg, r_hb, n_hb, r_hval, n_hval, r_hsat, n_hsat;
    logic r_out_valid, n_out_valid;
    logic [C-1:0] r_or, n_or, r_og, n_og, r_ob, n_ob;

    logic out_free, ge;
    logic [C-1:0] q_fin;
    logic [RW-1:0] dividend;

    assign out_free = !r_out_valid || !i_stall;
    assign ge       = (r_rem >= r_den);
    assign q_fin    = {r_q[C-2:0], ge};
    // 510*diff + mx
    assign dividend = (RW'(i_item.diff) << 9) - (RW'(i_item.diff) << 1) + RW'(i_item.mx);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_den       = r_den;
        n_q         = r_q;
        n_cur       = r_cur;
        n_hr        = r_hr;
        n_hg        = r_hg;
        n_hb        = r_hb;
        n_hval      = r_hval;
        n_hsat      = r_hsat;
        n_out_valid = r_out_valid && i_stall;
        n_or        = r_or;
        n_og        = r_og;
        n_ob        = r_ob;
        o_pop       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_avail && out_free) begin
                    o_pop = 1'b1;
                    n_cur = i_item;
                    if (i_item.qual && (i_item.mx > r_hval)) begin
                        // candidate beats held value: resolve saturation first
                        n_state = S_DIV;
                        n_cnt   = 3'd7;
                        n_rem   = dividend;
                        n_den   = RW'({i_item.mx, 1'b0}) << 7;
                        n_q     = '0;
                    end else if (i_item.last) begin
                        n_out_valid = 1'b1;
                        n_or = i_item.has_image ? r_hr : '0;
                        n_og = i_item.has_image ? r_hg : '0;
                        n_ob = i_item.has_image ? r_hb : '0;
                        n_hr = bpq_pkg::GRAY_LEVEL;
                        n_hg = bpq_pkg::GRAY_LEVEL;
                        n_hb = bpq_pkg::GRAY_LEVEL;
                        n_hval = bpq_pkg::GRAY_LEVEL;
                        n_hsat = '0;
                    end
                end
            end
            S_DIV: begin
                n_rem = ge ? r_rem - r_den : r_rem;
                n_den = r_den >> 1;
                n_q   = q_fin;
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_state = S_IDLE;
                    // sat > hsat - 10, signed, written as sat + 10 > hsat
                    if (({1'b0, q_fin} + bpq_pkg::SAT_OFFSET) > {1'b0, r_hsat}) begin
                        n_hr   = r_cur.red;
                        n_hg   = r_cur.green;
                        n_hb   = r_cur.blue;
                        n_hval = r_cur.mx;
                        n_hsat = q_fin;
                    end
                    if (r_cur.last) begin
                        n_out_valid = 1'b1;
                        n_or = r_cur.has_image ? n_hr : '0;
                        n_og = r_cur.has_image ? n_hg : '0;
                        n_ob = r_cur.has_image ? n_hb : '0;
                        n_hr = bpq_pkg::GRAY_LEVEL;
                        n_hg = bpq_pkg::GRAY_LEVEL;
                        n_hb = bpq_pkg::GRAY_LEVEL;
                        n_hval = bpq_pkg::GRAY_LEVEL;
                        n_hsat = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 3'd0;
            r_out_valid <= 1'b0;
            r_hr        <= bpq_pkg::GRAY_LEVEL;
            r_hg        <= bpq_pkg::GRAY_LEVEL;
            r_hb        <= bpq_pkg::GRAY_LEVEL;
            r_hval      <= bpq_pkg::GRAY_LEVEL;
            r_hsat      <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_hr        <= n_hr;
            r_hg        <= n_hg;
            r_hb        <= n_hb;
            r_hval      <= n_hval;
            r_hsat      <= n_hsat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_q   <= n_q;
        r_cur <= n_cur;
        r_or  <= n_or;
        r_og  <= n_og;
        r_ob  <= n_ob;
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_or;
    assign o_out_green = r_og;
    assign o_out_blue  = r_ob;

`ifndef ASSERT_OFF
    a_no_pop_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_pop)
        else $error("queue popped while divider busy");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_DIV) |=> (r_cnt == 3'd7))
        else $error("divider did not start at top bit");
    a_hval_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hval >= bpq_pkg::GRAY_LEVEL)
        else $error("held value below gray level");
    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_out_valid || !i_stall))
        else $error("item taken while result register blocked");
`endif

endmodule

[src/brightest_pixel_in_quadrant_core.sv]
// top level of the brightest pixel in quadrant block: config registers,
// front classifier, queue and back end; depends on bpq_pkg and submodules
`timescale 1ns / 1ps
// path: queue, then back end; a pixel that beats the held value first passes the
//   8-step saturation divider in the back end
// throughput: one pixel per cycle while pixels miss the held value and i_stall is
//   low; a beating candidate holds the back end; o_stall rises when the queue fills
// reset: synchronous active low; config to zero, held colour to gray 40

module brightest_pixel_in_quadrant_core #(
    parameter int MAX_SIDE = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [bpq_pkg::COORD_W-1:0]   i_cfg_data,
    // pixel input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [bpq_pkg::COORD_W-1:0]   i_col,
    input  logic [bpq_pkg::COORD_W-1:0]   i_row,
    input  logic [bpq_pkg::CHAN_W-1:0]    i_red,
    input  logic [bpq_pkg::CHAN_W-1:0]    i_green,
    input  logic [bpq_pkg::CHAN_W-1:0]    i_blue,
    input  logic                          i_last_pixel,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bpq_pkg::CHAN_W-1:0]    o_out_red,
    output logic [bpq_pkg::CHAN_W-1:0]    o_out_green,
    output logic [bpq_pkg::CHAN_W-1:0]    o_out_blue
);

    bpq_pkg::t_cfg  r_cfg;
    bpq_pkg::t_item push_item, pop_item;
    logic push, full, avail, pop;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpq_pkg::CFG_REGION: r_cfg.region <= i_cfg_data[1:0];
                bpq_pkg::CFG_WIDTH:  r_cfg.width  <= i_cfg_data;
                bpq_pkg::CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                default: ;  // unmapped index, transfer dropped
            endcase
        end
    end

    // front: window test, max/min, push into queue
    bpq_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_valid      (i_valid),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_last_pixel (i_last_pixel),
        .i_cfg        (r_cfg),
        .i_full       (full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_item       (push_item)
    );

    // queue decouples the front from the divider stalls
    bpq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .o_avail (avail),
        .i_pop   (pop),
        .o_item  (pop_item)
    );

    // back: saturation, compare-select, result register
    bpq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avail     (avail),
        .i_item      (pop_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue)
    );

endmodule
